[rtl/uvl_pkg.sv]
// Shared types, constants and lookup tables for the unison voice layout block.
package uvl_pkg;

  // Default voice limit handed to the top level
  localparam int MAX_VOICES_DEF = 10;

  // Jitter table in thousandths; row n-2 serves a group of n voices
  localparam int ROM_ROWS = 9;
  localparam int ROM_COLS = 10;
  localparam int JITTER_ROM [ROM_ROWS][ROM_COLS] = '{
    '{   1,   -1,    0,    0,    0,    0,    0,    0,    0,    0},
    '{-108,  -61,  163,    0,    0,    0,    0,    0,    0,    0},
    '{  23,  -67, -124,  168,    0,    0,    0,    0,    0,    0},
    '{-135,   94,   22, -122,  143,    0,    0,    0,    0,    0},
    '{ -76, -111,  123,  -93,  178,  -62,    0,    0,    0,    0},
    '{  61,  -66,   56,  -83,  215,  123,  -18,    0,    0,    0},
    '{ -13,  -61,  115,  231,  -24, -172,  156,  155,    0,    0},
    '{  23,  -65, -128,  169, -127,  149, -103,  -62,  163,    0},
    '{ -68,   54,  -86,  212,  126,  -14,   23,  -63, -128,  163}
  };

  // Datapath widths, sized from the worst-case magnitudes of each term
  localparam int ROM_W   = 9;   // signed jitter entry
  localparam int JR_W    = 25;  // jitter amount times entry
  localparam int BASE_W  = 31;  // cent scale times (2i - m)
  localparam int POSB_W  = 32;  // position numerator before jitter
  localparam int OFFC_W  = 30;  // cents rounding offset
  localparam int OFFS_W  = 31;  // phase rounding offset
  localparam int MJR_W   = 29;  // m times jitter
  localparam int NJR_W   = 30;  // 2n times jitter
  localparam int XY_W    = 31;  // cents and phase inner terms
  localparam int POSN_W  = 33;  // position numerator
  localparam int PRODC_W = 46;  // width times cents term
  localparam int PRODS_W = 47;  // spread times phase term
  localparam int CNUM_W  = 47;  // cents numerator
  localparam int NUM_W   = 48;  // widest numerator fed to the divider
  localparam int Q_W     = 20;  // signed quotient out of the divider

  // Fixed-point scale constants
  localparam logic [26:0] CENT_SCALE = 27'd65536000;   // 2^16 * 1000
  localparam logic [27:0] POS_SCALE  = 28'd262144000;  // 2 * 16384 * 8000
  localparam logic [12:0] POS_HALF   = 13'd8000;

  // Divider constants: shift by 2^a, then divide by 125, then by a small divisor
  localparam int SH_POS   = 7;
  localparam int SH_CENTS = 20;
  localparam int SH_PHASE = 21;
  localparam logic [27:0] BIAS125 = 28'd131072000;  // 125 * 2^20
  localparam logic [28:0] M125    = 29'd274877907;  // ceil(2^35 / 125)
  localparam int          M125_SH = 35;
  localparam logic [21:0] REBIAS  = 22'd403456;     // 2^20 - 645120
  localparam int          MD_SH   = 25;

  // Output constants
  localparam logic signed [15:0] POS_SINGLE = 16'sd8192;
  localparam logic        [15:0] PAN_CENTER = 16'd32768;
  localparam logic signed [15:0] S16_MAX    = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN    = -16'sh8000;

  // Sequencer step numbers
  localparam logic [2:0] STEP_POS   = 3'd4;
  localparam logic [2:0] STEP_CENTS = 3'd5;
  localparam logic [2:0] STEP_PHASE = 3'd6;
  localparam int         NUM_STAGES = 5;

  typedef enum logic [1:0] {
    Q_POS,
    Q_CENTS,
    Q_PHASE
  } quant_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                  load;
    logic                  next_voice;
    logic [NUM_STAGES-1:0] stage_en;
    logic                  issue;
    quant_e                issue_tag;
    logic                  emit;
  } cmd_t;

  typedef struct packed {
    logic single_in;
    logic last;
    logic phase_done;
  } status_t;

  // ceil(2^25 / d) for small divisors
  function automatic logic [25:0] recip_small(input logic [3:0] d);
    logic [25:0] r;
    unique case (d)
      4'd1:    r = 26'd33554432;
      4'd2:    r = 26'd16777216;
      4'd3:    r = 26'd11184811;
      4'd4:    r = 26'd8388608;
      4'd5:    r = 26'd6710887;
      4'd6:    r = 26'd5592406;
      4'd7:    r = 26'd4793491;
      4'd8:    r = 26'd4194304;
      4'd9:    r = 26'd3728271;
      4'd10:   r = 26'd3355444;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 645120 / d, the bias that keeps the small division non-negative
  function automatic logic [19:0] bias_div(input logic [3:0] d);
    logic [19:0] b;
    unique case (d)
      4'd1:    b = 20'd645120;
      4'd2:    b = 20'd322560;
      4'd3:    b = 20'd215040;
      4'd4:    b = 20'd161280;
      4'd5:    b = 20'd129024;
      4'd6:    b = 20'd107520;
      4'd7:    b = 20'd92160;
      4'd8:    b = 20'd80640;
      4'd9:    b = 20'd71680;
      4'd10:   b = 20'd64512;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

[rtl/unison_voice_layout_top.sv]
// Top level of the unison voice layout: controller plus datapath.
// A group of n >= 2 voices takes each voice through the 7 sequencer steps, the 5-stage divider
// and the emit state, which waits while the output register holds a result that is not taken;
// a single voice goes straight from idle to emit.
// A new group is accepted once the last voice sits in the output register.
// Reset (async, active low) empties the output register and returns the sequencer to idle.
module unison_voice_layout_top #(
  parameter int MAX_VOICES = uvl_pkg::MAX_VOICES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               enabled_i,
  input  logic [3:0]         voice_count_i,
  input  logic [15:0]        jitter_amount_i,
  input  logic [14:0]        detune_width_i,
  input  logic [15:0]        pan_spread_i,
  input  logic [15:0]        phase_spread_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         voice_index_o,
  output logic signed [15:0] detune_position_o,
  output logic signed [15:0] detune_cents_o,
  output logic [15:0]        pan_o,
  output logic [15:0]        phase_o,
  output logic               last_o
);

  uvl_pkg::cmd_t    cmd;
  uvl_pkg::status_t status;

  uvl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  uvl_dp #(
    .MAX_VOICES (MAX_VOICES)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .enabled_i         (enabled_i),
    .voice_count_i     (voice_count_i),
    .jitter_amount_i   (jitter_amount_i),
    .detune_width_i    (detune_width_i),
    .pan_spread_i      (pan_spread_i),
    .phase_spread_i    (phase_spread_i),
    .voice_index_o     (voice_index_o),
    .detune_position_o (detune_position_o),
    .detune_cents_o    (detune_cents_o),
    .pan_o             (pan_o),
    .phase_o           (phase_o),
    .last_o            (last_o)
  );

  // An accepted group blocks the input on the following cycle
  a_accept_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready right after a group transaction");

  // The final voice returns the sequencer to idle
  a_last_to_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last) |=> in_ready_o)
    else $error("sequencer not idle after the last voice");

  // Never overwrite a result that has not been taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before its transaction");

  // Divider results only arrive while a group is in progress
  a_div_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.phase_done |-> !in_ready_o)
    else $error("divider result while the sequencer is idle");

endmodule

[rtl/uvl_div.sv]
// Pipelined floor divider: shift by 2^a, divide by 125, divide by a small divisor.
module uvl_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                issue_i,
  input  uvl_pkg::quant_e                     tag_i,
  input  logic signed [uvl_pkg::NUM_W-1:0]    num_i,
  input  logic        [3:0]                   div_i,
  output logic                                res_valid_o,
  output uvl_pkg::quant_e                     res_tag_o,
  output logic signed [uvl_pkg::Q_W-1:0]      res_o
);

  localparam int NS = uvl_pkg::NUM_STAGES;

  logic [NS-1:0]   valid_q;
  uvl_pkg::quant_e tag_q [NS];
  logic [3:0]      div_q [NS-1];

  logic signed [uvl_pkg::NUM_W-1:0] shifted;
  logic signed [26:0]               x27;
  logic signed [28:0]               xb_full;
  logic        [27:0]               xb_d, xb_q;
  logic        [56:0]               p1_full;
  logic        [21:0]               q1_d, q1_q;
  logic        [21:0]               yb_full;
  logic        [20:0]               yb_d, yb_q;
  logic        [46:0]               p2_full;
  logic        [20:0]               q2_d, q2_q;
  logic signed [21:0]               res_full;
  logic signed [uvl_pkg::Q_W-1:0]   res_d, res_q;

  // Pick the power-of-two part of the divisor and bias into the positive range
  always_comb begin
    unique case (tag_i)
      uvl_pkg::Q_POS:   shifted = num_i >>> uvl_pkg::SH_POS;
      uvl_pkg::Q_CENTS: shifted = num_i >>> uvl_pkg::SH_CENTS;
      default:          shifted = num_i >>> uvl_pkg::SH_PHASE;
    endcase
    x27     = shifted[26:0];
    xb_full = $signed({{2{x27[26]}}, x27}) + $signed({1'b0, uvl_pkg::BIAS125});
    xb_d    = xb_full[27:0];
  end

  // Divide by 125 through a reciprocal
  assign p1_full = 57'(xb_q) * 57'(uvl_pkg::M125);
  assign q1_d    = p1_full[56:uvl_pkg::M125_SH];

  // Swap the 125 bias for one that every small divisor splits evenly
  assign yb_full = q1_q - uvl_pkg::REBIAS;
  assign yb_d    = yb_full[20:0];

  // Divide by the small divisor through a reciprocal table
  assign p2_full = 47'(yb_q) * 47'(uvl_pkg::recip_small(div_q[2]));
  assign q2_d    = p2_full[45:uvl_pkg::MD_SH];

  // Remove the bias
  assign res_full = $signed({1'b0, q2_q}) - $signed({2'b00, uvl_pkg::bias_div(div_q[3])});
  assign res_d    = res_full[uvl_pkg::Q_W-1:0];

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[NS-2:0], issue_i};
    end
  end

  // Advance tags, divisors and data
  always_ff @(posedge clk_i) begin
    tag_q[0] <= tag_i;
    div_q[0] <= div_i;
    for (int k = 1; k < NS; k++) begin
      tag_q[k] <= tag_q[k-1];
    end
    for (int k = 1; k < NS - 1; k++) begin
      div_q[k] <= div_q[k-1];
    end
    xb_q  <= xb_d;
    q1_q  <= q1_d;
    yb_q  <= yb_d;
    q2_q  <= q2_d;
    res_q <= res_d;
  end

  assign res_valid_o = valid_q[NS-1];
  assign res_tag_o   = tag_q[NS-1];
  assign res_o       = res_q;

endmodule

[rtl/uvl_dp.sv]
// Datapath: group registers, per-voice arithmetic, shared divider and result register.
module uvl_dp #(
  parameter int MAX_VOICES = uvl_pkg::MAX_VOICES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  uvl_pkg::cmd_t        cmd_i,
  output uvl_pkg::status_t     status_o,
  input  logic                 enabled_i,
  input  logic [3:0]           voice_count_i,
  input  logic [15:0]          jitter_amount_i,
  input  logic [14:0]          detune_width_i,
  input  logic [15:0]          pan_spread_i,
  input  logic [15:0]          phase_spread_i,
  output logic [3:0]           voice_index_o,
  output logic signed [15:0]   detune_position_o,
  output logic signed [15:0]   detune_cents_o,
  output logic [15:0]          pan_o,
  output logic [15:0]          phase_o,
  output logic                 last_o
);

  localparam logic [3:0] MAX_N = 4'(MAX_VOICES);

  // Group registers
  logic [3:0]  n_in;
  logic [3:0]  n_q;
  logic        single_q;
  logic [3:0]  i_q;
  logic [15:0] j_q, p_q, s_q;
  logic [14:0] w_q;
  logic [3:0]  m;
  logic [3:0]  row;

  // Per-voice pipeline registers
  logic signed [uvl_pkg::ROM_W-1:0]   r;
  logic signed [25:0]                 jr_full;
  logic signed [uvl_pkg::JR_W-1:0]    jr_q;
  logic signed [5:0]                  k6;
  logic signed [32:0]                 base_full;
  logic signed [uvl_pkg::BASE_W-1:0]  base_q;
  logic        [uvl_pkg::POSB_W-1:0]  posb_d, posb_q;
  logic        [uvl_pkg::OFFC_W-1:0]  offc_d, offc_q;
  logic        [uvl_pkg::OFFS_W-1:0]  offs_d, offs_q;
  logic signed [29:0]                 mjr_full;
  logic signed [30:0]                 njr_full;
  logic signed [uvl_pkg::MJR_W-1:0]   mjr_q;
  logic signed [uvl_pkg::NJR_W-1:0]   njr_q;
  logic signed [uvl_pkg::XY_W-1:0]    x_d, x_q, y_d, y_q;
  logic signed [uvl_pkg::POSN_W-1:0]  posn_d, posn_q;
  logic signed [46:0]                 prodc_full;
  logic signed [47:0]                 prods_full;
  logic signed [uvl_pkg::PRODC_W-1:0] prodc_q;
  logic signed [uvl_pkg::PRODS_W-1:0] prods_q;
  logic signed [uvl_pkg::CNUM_W-1:0]  cnum_d, cnum_q;
  logic signed [uvl_pkg::NUM_W-1:0]   snum_d, snum_q;

  // Pan terms
  logic [17:0] pan_sum, pan_diff;
  logic [15:0] pan_plus, pan_minus, pan_d, pan_q;
  logic [3:0]  half_n;

  // Divider hookup and captured quotients
  logic signed [uvl_pkg::NUM_W-1:0] div_num;
  logic        [3:0]                div_d;
  logic                             res_valid;
  uvl_pkg::quant_e                  res_tag;
  logic signed [uvl_pkg::Q_W-1:0]   res;
  logic signed [uvl_pkg::Q_W-1:0]   pos_q, cents_q, phase_q;

  // Clamp the requested voice count
  always_comb begin
    if (!enabled_i || voice_count_i == 4'd0) begin
      n_in = 4'd1;
    end else if (voice_count_i > MAX_N) begin
      n_in = MAX_N;
    end else begin
      n_in = voice_count_i;
    end
  end

  assign m   = n_q - 4'd1;
  assign row = n_q - 4'd2;

  // Hold the group and step the voice counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_q <= 1'b0;
      n_q      <= 4'd1;
      i_q      <= '0;
    end else if (cmd_i.load) begin
      single_q <= (n_in == 4'd1);
      n_q      <= n_in;
      i_q      <= '0;
    end else if (cmd_i.next_voice) begin
      i_q <= i_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      j_q <= jitter_amount_i;
      w_q <= detune_width_i;
      p_q <= pan_spread_i;
      s_q <= phase_spread_i;
    end
  end

  function automatic logic signed [uvl_pkg::ROM_W-1:0] ROM_W_CAST(input int v);
    return uvl_pkg::ROM_W'(v);
  endfunction

  // Step 0: jitter product, scaled bases and rounding offsets
  always_comb begin
    r         = ROM_W_CAST(uvl_pkg::JITTER_ROM[row][i_q]);
    jr_full   = $signed({1'b0, j_q}) * r;
    k6        = $signed({1'b0, i_q, 1'b0}) - $signed({2'b00, m});
    base_full = k6 * $signed({1'b0, uvl_pkg::CENT_SCALE});
    posb_d    = uvl_pkg::POS_SCALE * i_q + uvl_pkg::POS_HALF * m;
    offc_d    = uvl_pkg::CENT_SCALE * m;
    offs_d    = uvl_pkg::CENT_SCALE * {n_q, 1'b0};
  end

  // Pan alternates right and left; the middle voice of an odd group sits centered
  assign pan_sum   = 18'd65537 + 18'(p_q);
  assign pan_diff  = 18'd65537 - 18'(p_q);
  assign pan_plus  = pan_sum[17] ? 16'hFFFF : pan_sum[16:1];
  assign pan_minus = pan_diff[16:1];
  assign half_n    = n_q >> 1;

  always_comb begin
    if (!n_q[0] || i_q < half_n) begin
      pan_d = i_q[0] ? pan_minus : pan_plus;
    end else if (i_q == half_n) begin
      pan_d = uvl_pkg::PAN_CENTER;
    end else begin
      pan_d = i_q[0] ? pan_plus : pan_minus;
    end
  end

  // Step 1: scale the jitter by m and by 2n
  assign mjr_full = jr_q * $signed({1'b0, m});
  assign njr_full = jr_q * $signed({1'b0, n_q, 1'b0});

  // Step 2: combine into the three inner terms
  assign x_d    = base_q - mjr_q;
  assign y_d    = base_q + njr_q;
  assign posn_d = $signed({1'b0, posb_q}) - $signed({mjr_q, 1'b0});

  // Step 3: apply width and spread
  assign prodc_full = $signed({1'b0, w_q}) * x_q;
  assign prods_full = $signed({1'b0, s_q}) * y_q;

  // Step 4: add the rounding offsets
  assign cnum_d = $signed({prodc_q, 1'b0}) + $signed({1'b0, offc_q});
  assign snum_d = $signed({prods_q, 1'b0}) + $signed({1'b0, offs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage_en[0]) begin
      jr_q   <= jr_full[uvl_pkg::JR_W-1:0];
      base_q <= base_full[uvl_pkg::BASE_W-1:0];
      posb_q <= posb_d;
      offc_q <= offc_d;
      offs_q <= offs_d;
      pan_q  <= pan_d;
    end
    if (cmd_i.stage_en[1]) begin
      mjr_q <= mjr_full[uvl_pkg::MJR_W-1:0];
      njr_q <= njr_full[uvl_pkg::NJR_W-1:0];
    end
    if (cmd_i.stage_en[2]) begin
      x_q    <= x_d;
      y_q    <= y_d;
      posn_q <= posn_d;
    end
    if (cmd_i.stage_en[3]) begin
      prodc_q <= prodc_full[uvl_pkg::PRODC_W-1:0];
      prods_q <= prods_full[uvl_pkg::PRODS_W-1:0];
    end
    if (cmd_i.stage_en[4]) begin
      cnum_q <= cnum_d;
      snum_q <= snum_d;
    end
  end

  // Select the numerator and divisor for the divider
  always_comb begin
    unique case (cmd_i.issue_tag)
      uvl_pkg::Q_POS: begin
        div_num = {{(uvl_pkg::NUM_W - uvl_pkg::POSN_W){posn_q[uvl_pkg::POSN_W-1]}}, posn_q};
        div_d   = m;
      end
      uvl_pkg::Q_CENTS: begin
        div_num = {cnum_q[uvl_pkg::CNUM_W-1], cnum_q};
        div_d   = m;
      end
      default: begin
        div_num = snum_q;
        div_d   = n_q;
      end
    endcase
  end

  uvl_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (cmd_i.issue),
    .tag_i       (cmd_i.issue_tag),
    .num_i       (div_num),
    .div_i       (div_d),
    .res_valid_o (res_valid),
    .res_tag_o   (res_tag),
    .res_o       (res)
  );

  // Capture quotients by tag
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      unique case (res_tag)
        uvl_pkg::Q_POS:   pos_q   <= res;
        uvl_pkg::Q_CENTS: cents_q <= res;
        default:          phase_q <= res;
      endcase
    end
  end

  function automatic logic signed [15:0] sat16(input logic signed [uvl_pkg::Q_W-1:0] v);
    logic signed [15:0] o;
    if (v > $signed(uvl_pkg::Q_W'(uvl_pkg::S16_MAX))) begin
      o = uvl_pkg::S16_MAX;
    end else if (v < $signed(uvl_pkg::Q_W'(uvl_pkg::S16_MIN))) begin
      o = uvl_pkg::S16_MIN;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

  // Load the result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      voice_index_o <= i_q;
      last_o        <= status_o.last;
      if (single_q) begin
        detune_position_o <= uvl_pkg::POS_SINGLE;
        detune_cents_o    <= '0;
        pan_o             <= uvl_pkg::PAN_CENTER;
        phase_o           <= '0;
      end else begin
        detune_position_o <= sat16(pos_q);
        detune_cents_o    <= sat16(cents_q);
        pan_o             <= pan_q;
        phase_o           <= phase_q[15:0];
      end
    end
  end

  // Report status
  assign status_o.single_in  = (n_in == 4'd1);
  assign status_o.last       = single_q || (i_q == m);
  assign status_o.phase_done = res_valid && (res_tag == uvl_pkg::Q_PHASE);

endmodule

[rtl/uvl_ctrl.sv]
// Controller: sequences the voice steps, the divider issues and the result register.
module uvl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  uvl_pkg::status_t  status_i,
  output uvl_pkg::cmd_t     cmd_o
);

  uvl_pkg::state_e state_q, state_d;
  logic [2:0]      step_q, step_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      uvl_pkg::ST_IDLE: begin
        step_d = '0;
        if (in_valid_i) begin
          state_d = status_i.single_in ? uvl_pkg::ST_EMIT : uvl_pkg::ST_CALC;
        end
      end
      uvl_pkg::ST_CALC: begin
        if (step_q == uvl_pkg::STEP_PHASE) begin
          state_d = uvl_pkg::ST_DRAIN;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      uvl_pkg::ST_DRAIN: begin
        if (status_i.phase_done) begin
          state_d = uvl_pkg::ST_EMIT;
        end
      end
      uvl_pkg::ST_EMIT: begin
        step_d = '0;
        if (slot_free) begin
          state_d = status_i.last ? uvl_pkg::ST_IDLE : uvl_pkg::ST_CALC;
        end
      end
      default: state_d = uvl_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.issue_tag  = uvl_pkg::Q_POS;
    in_ready_o       = (state_q == uvl_pkg::ST_IDLE);
    cmd_o.load       = in_ready_o && in_valid_i;
    if (state_q == uvl_pkg::ST_CALC) begin
      cmd_o.stage_en = uvl_pkg::NUM_STAGES'(1) << step_q;
      unique case (step_q)
        uvl_pkg::STEP_POS: begin
          cmd_o.issue     = 1'b1;
          cmd_o.issue_tag = uvl_pkg::Q_POS;
        end
        uvl_pkg::STEP_CENTS: begin
          cmd_o.issue     = 1'b1;
          cmd_o.issue_tag = uvl_pkg::Q_CENTS;
        end
        uvl_pkg::STEP_PHASE: begin
          cmd_o.issue     = 1'b1;
          cmd_o.issue_tag = uvl_pkg::Q_PHASE;
        end
        default: cmd_o.issue = 1'b0;
      endcase
    end
    cmd_o.emit       = (state_q == uvl_pkg::ST_EMIT) && slot_free;
    cmd_o.next_voice = cmd_o.emit && !status_i.last;
  end

  // Track the result register occupancy
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= uvl_pkg::ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
